### rtl/core/byte_geometric_mean_unit_assert.svh
// ----------------------------------------------------------------------------
// byte_geometric_mean_unit assertion macros
// Shared property shapes for the port checker.
// ----------------------------------------------------------------------------
`ifndef BYTE_GEOMETRIC_MEAN_UNIT_ASSERT_SVH
`define BYTE_GEOMETRIC_MEAN_UNIT_ASSERT_SVH

// same-cycle implication
`define BGM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BGM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/bgm_pkg.sv
// ----------------------------------------------------------------------------
// bgm_pkg
// Constants shared by the geometric mean blocks, and the front end's log table.
// ----------------------------------------------------------------------------
package bgm_pkg;

  localparam int FRAC_BITS = 16;
  localparam int QB = 56;
  localparam int FRAC_GAP = QB - FRAC_BITS;
  localparam int MEAN_W = 8 + FRAC_BITS;
  localparam int LOG_W = FRAC_BITS + 3;
  localparam longint unsigned MAX_ITEMS_DEF = 64'd16777216;

  // ln(2) in Q.56, atanh series with truncating steps
  localparam logic [63:0] LN2_Q = 64'd49946518145322858;
  localparam logic [63:0] ONE_Q = 64'd1 << QB;
  localparam logic [63:0] MEAN_MAX = 64'd255 << FRAC_BITS;
  localparam logic [63:0] MEAN_MIN = 64'd1 << FRAC_BITS;

  typedef logic [255:0][LOG_W-1:0] log_tab_t;

  // ln(k) rounded to Q.FRAC_BITS, entry 0 unused
  function automatic log_tab_t build_log_tab();
    log_tab_t tab;
    real v;
    tab = '0;
    for (int k = 1; k < 256; k++) begin
      v = $ln(real'(k)) * real'(longint'(1) << FRAC_BITS) + 0.5;
      tab[k] = LOG_W'($rtoi(v));
    end
    return tab;
  endfunction

  localparam log_tab_t LOG_TAB = build_log_tab();

endpackage

### rtl/core/bgm_front.sv
// ----------------------------------------------------------------------------
// bgm_front
// Accepts bytes, accumulates table logs and count, posts closed sets.
// ----------------------------------------------------------------------------
module bgm_front #(
  parameter longint unsigned MAX_ITEMS = bgm_pkg::MAX_ITEMS_DEF,
  parameter int CNT_W = 25,
  parameter int SUM_W = 44
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             accept,
  input  logic [7:0]       sample,
  input  logic             last,
  output logic             push,
  output logic [SUM_W-1:0] push_sum,
  output logic [CNT_W-1:0] push_cnt
);

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic [CNT_W-1:0] cnt_inc;
  logic [SUM_W-1:0] sum_inc;

  always_comb begin
    cnt_inc = cnt_r;
    sum_inc = sum_r;
    if (cnt_r < CNT_W'(MAX_ITEMS)) begin
      cnt_inc = cnt_r + CNT_W'(1);
      sum_inc = sum_r + SUM_W'(bgm_pkg::LOG_TAB[sample]);
    end
    cnt_nxt = cnt_r;
    sum_nxt = sum_r;
    if (accept) begin
      cnt_nxt = last ? '0 : cnt_inc;
      sum_nxt = last ? '0 : sum_inc;
    end
  end

  assign push     = accept && last;
  assign push_sum = sum_inc;
  assign push_cnt = cnt_inc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      sum_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      sum_r <= sum_nxt;
    end
  end

endmodule

### rtl/core/bgm_queue.sv
// ----------------------------------------------------------------------------
// bgm_queue
// Two-entry queue of closed sets between front and back.
// ----------------------------------------------------------------------------
module bgm_queue #(
  parameter int CNT_W = 25,
  parameter int SUM_W = 44
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [SUM_W-1:0] push_sum,
  input  logic [CNT_W-1:0] push_cnt,
  input  logic             pop,
  output logic             empty,
  output logic             full,
  output logic [SUM_W-1:0] head_sum,
  output logic [CNT_W-1:0] head_cnt
);

  logic [SUM_W-1:0] sum_q [2];
  logic [CNT_W-1:0] cnt_q [2];
  logic             wp_r, rp_r;
  logic [1:0]       fill_r;

  assign empty    = (fill_r == 2'd0);
  assign full     = (fill_r == 2'd2);
  assign head_sum = sum_q[rp_r];
  assign head_cnt = cnt_q[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      sum_q[wp_r] <= push_sum;
      cnt_q[wp_r] <= push_cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r   <= 1'b0;
      rp_r   <= 1'b0;
      fill_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      fill_r <= fill_r + 2'(push) - 2'(pop);
    end
  end

endmodule

### rtl/core/bgm_div.sv
// ----------------------------------------------------------------------------
// bgm_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bgm_div #(
  parameter int DVD_W = 84,
  parameter int DVS_W = 25
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quotient
);

  localparam int CW = $clog2(DVD_W + 1);

  logic [DVD_W-1:0] q_r;
  logic [DVS_W-1:0] rem_r, dvs_r, rem_nxt;
  logic [DVS_W:0]   rem_sh;
  logic             ge;
  logic [CW-1:0]    cnt_r;
  logic             run_r, done_r;

  always_comb begin
    rem_sh  = {rem_r, q_r[DVD_W-1]};
    ge      = (rem_sh >= {1'b0, dvs_r});
    rem_nxt = ge ? DVS_W'(rem_sh - {1'b0, dvs_r}) : DVS_W'(rem_sh);
  end

  assign done     = done_r;
  assign quotient = q_r;

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (run_r) begin
      q_r   <= {q_r[DVD_W-2:0], ge};
      rem_r <= rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= CW'(DVD_W);
      end else if (run_r) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

### rtl/core/bgm_back.sv
// ----------------------------------------------------------------------------
// bgm_back
// Per-set sequencer: mean log by division, then exp by range reduction
// and a Taylor series on a split multiplier and the shared divider.
// ----------------------------------------------------------------------------
module bgm_back #(
  parameter int CNT_W = 25,
  parameter int SUM_W = 44
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         empty,
  input  logic [SUM_W-1:0]             head_sum,
  input  logic [CNT_W-1:0]             head_cnt,
  output logic                         pop,
  output logic                         out_valid,
  output logic [bgm_pkg::MEAN_W-1:0]   out_mean_value,
  output logic [CNT_W-1:0]             out_item_count
);

  localparam int DVD_W = (SUM_W + bgm_pkg::FRAC_GAP > 64) ?
                         SUM_W + bgm_pkg::FRAC_GAP : 64;
  localparam int DVS_W = (CNT_W > 6) ? CNT_W : 6;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_DIV   = 3'd1;
  localparam logic [2:0] ST_KRED  = 3'd2;
  localparam logic [2:0] ST_MUL   = 3'd3;
  localparam logic [2:0] ST_TDIV  = 3'd4;
  localparam logic [2:0] ST_ROUND = 3'd5;

  logic [2:0]       st_r;
  logic [63:0]      x_r, t_r, esum_r;
  logic [127:0]     acc_r, acc_nxt;
  logic [1:0]       p_r;
  logic [5:0]       i_r;
  logic [2:0]       k_r;
  logic [CNT_W-1:0] cnt_r;
  logic             div_go_r;
  logic [DVD_W-1:0] dvd_r;
  logic [DVS_W-1:0] dvs_r;
  logic             div_done;
  logic [DVD_W-1:0] div_q;
  logic [63:0]      q64;
  logic [31:0]      a_sel, b_sel;
  logic [63:0]      pp;
  logic [6:0]       pp_sh;
  logic [63:0]      shifted, rnd;
  logic             out_valid_r;
  logic [bgm_pkg::MEAN_W-1:0] mean_r;
  logic [CNT_W-1:0] out_cnt_r;

  bgm_div #(.DVD_W(DVD_W), .DVS_W(DVS_W)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_go_r),
    .dividend (dvd_r),
    .divisor  (dvs_r),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    q64     = div_q[63:0];
    a_sel   = p_r[1] ? t_r[63:32] : t_r[31:0];
    b_sel   = p_r[0] ? x_r[63:32] : x_r[31:0];
    pp      = a_sel * b_sel;
    pp_sh   = 7'({1'b0, p_r[1]} + {1'b0, p_r[0]}) << 5;
    acc_nxt = acc_r + ({64'd0, pp} << pp_sh);
    shifted = esum_r >> (6'd39 - {3'd0, k_r});
    rnd     = (shifted + 64'd1) >> 1;
  end

  assign pop            = (st_r == ST_IDLE) && !empty;
  assign out_valid      = out_valid_r;
  assign out_mean_value = mean_r;
  assign out_item_count = out_cnt_r;

  always_ff @(posedge clk) begin
    case (st_r)
      ST_IDLE: begin
        dvd_r <= DVD_W'({head_sum, bgm_pkg::FRAC_GAP'(0)});
        dvs_r <= DVS_W'(head_cnt);
        cnt_r <= head_cnt;
      end
      ST_DIV: begin
        if (div_done) begin
          x_r <= q64;
        end
      end
      ST_KRED: begin
        if (k_r != 3'd7 && x_r >= bgm_pkg::LN2_Q) begin
          x_r <= x_r - bgm_pkg::LN2_Q;
        end else begin
          if (x_r > bgm_pkg::ONE_Q) x_r <= bgm_pkg::ONE_Q;
          t_r    <= bgm_pkg::ONE_Q;
          esum_r <= bgm_pkg::ONE_Q;
          acc_r  <= '0;
        end
      end
      ST_MUL: begin
        acc_r <= acc_nxt;
        if (p_r == 2'd3) begin
          dvd_r <= DVD_W'(acc_nxt[bgm_pkg::QB+63:bgm_pkg::QB]);
          dvs_r <= DVS_W'(i_r);
        end
      end
      ST_TDIV: begin
        if (div_done) begin
          t_r    <= q64;
          esum_r <= esum_r + q64;
          acc_r  <= '0;
        end
      end
      ST_ROUND: begin
        if (rnd > bgm_pkg::MEAN_MAX) begin
          mean_r <= bgm_pkg::MEAN_W'(bgm_pkg::MEAN_MAX);
        end else if (rnd < bgm_pkg::MEAN_MIN) begin
          mean_r <= bgm_pkg::MEAN_W'(bgm_pkg::MEAN_MIN);
        end else begin
          mean_r <= bgm_pkg::MEAN_W'(rnd);
        end
        out_cnt_r <= cnt_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      div_go_r    <= 1'b0;
      out_valid_r <= 1'b0;
      p_r         <= 2'd0;
      i_r         <= 6'd1;
      k_r         <= 3'd0;
    end else begin
      div_go_r    <= 1'b0;
      out_valid_r <= 1'b0;
      case (st_r)
        ST_IDLE: begin
          if (!empty) begin
            div_go_r <= 1'b1;
            st_r     <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            k_r  <= 3'd0;
            st_r <= ST_KRED;
          end
        end
        ST_KRED: begin
          if (k_r != 3'd7 && x_r >= bgm_pkg::LN2_Q) begin
            k_r <= k_r + 3'd1;
          end else begin
            i_r  <= 6'd1;
            p_r  <= 2'd0;
            st_r <= ST_MUL;
          end
        end
        ST_MUL: begin
          p_r <= p_r + 2'd1;
          if (p_r == 2'd3) begin
            div_go_r <= 1'b1;
            st_r     <= ST_TDIV;
          end
        end
        ST_TDIV: begin
          if (div_done) begin
            if (i_r == 6'd39 || q64 == 64'd0) begin
              st_r <= ST_ROUND;
            end else begin
              i_r  <= i_r + 6'd1;
              p_r  <= 2'd0;
              st_r <= ST_MUL;
            end
          end
        end
        ST_ROUND: begin
          out_valid_r <= 1'b1;
          st_r        <= ST_IDLE;
        end
        default: begin
          st_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

### rtl/core/byte_geometric_mean_unit.sv
// ----------------------------------------------------------------------------
// byte_geometric_mean_unit
// Streaming geometric mean of bytes by the sum of logs.
// ----------------------------------------------------------------------------
// channel | ports                                   | handshake
// input   | in_sample, in_last                      | start && !busy
// result  | out_mean_value, out_item_count          | out_valid, one cycle
//
// Bytes are taken one per cycle while busy is low; the log table lookup and add are combinational.
// A closed set waits in a two-entry queue; the back end takes one set at a time and
// runs a divide (D = divider width, 84 by default), up to K = 7 range steps and up to
// T = 39 series terms, each a split multiply and a divide on the bit-serial divider.
// busy rises only while both queue entries hold sets. Reset is synchronous.
// ----------------------------------------------------------------------------
module byte_geometric_mean_unit #(
  parameter longint unsigned MAX_ITEMS = bgm_pkg::MAX_ITEMS_DEF,
  localparam int CNT_W = $clog2(MAX_ITEMS + 1),
  localparam int SUM_W = CNT_W + bgm_pkg::LOG_W
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic [7:0]                 in_sample,
  input  logic                       in_last,
  output logic                       out_valid,
  output logic [bgm_pkg::MEAN_W-1:0] out_mean_value,
  output logic [CNT_W-1:0]           out_item_count
);

  logic             push, pop, empty, full;
  logic [SUM_W-1:0] push_sum, head_sum;
  logic [CNT_W-1:0] push_cnt, head_cnt;

  assign busy = full;

  bgm_front #(.MAX_ITEMS(MAX_ITEMS), .CNT_W(CNT_W), .SUM_W(SUM_W)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (start && !busy),
    .sample   (in_sample),
    .last     (in_last),
    .push     (push),
    .push_sum (push_sum),
    .push_cnt (push_cnt)
  );

  bgm_queue #(.CNT_W(CNT_W), .SUM_W(SUM_W)) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_sum (push_sum),
    .push_cnt (push_cnt),
    .pop      (pop),
    .empty    (empty),
    .full     (full),
    .head_sum (head_sum),
    .head_cnt (head_cnt)
  );

  bgm_back #(.CNT_W(CNT_W), .SUM_W(SUM_W)) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .empty          (empty),
    .head_sum       (head_sum),
    .head_cnt       (head_cnt),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_mean_value (out_mean_value),
    .out_item_count (out_item_count)
  );

endmodule

### rtl/core/bgm_checker.sv
// ----------------------------------------------------------------------------
// bgm_checker
// Port-level checks on the geometric mean unit's results.
// ----------------------------------------------------------------------------
`include "byte_geometric_mean_unit_assert.svh"

module bgm_checker #(
  parameter int CNT_W = 25
) (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       busy,
  input logic                       out_valid,
  input logic [bgm_pkg::MEAN_W-1:0] out_mean_value,
  input logic [CNT_W-1:0]           out_item_count
);

  `BGM_ASSERT_IMP(a_mean_range, out_valid, out_mean_value >= 24'd65536 && out_mean_value <= 24'd16711680, "mean out of range")
  `BGM_ASSERT_IMP(a_count_nonzero, out_valid, out_item_count != '0, "empty set reported")
  `BGM_ASSERT_NXT(a_result_spacing, out_valid, !out_valid, "back-to-back results")
  `BGM_ASSERT_NXT(a_full_holds, busy && !out_valid, busy, "busy dropped without a result")

endmodule

bind byte_geometric_mean_unit bgm_checker #(.CNT_W(CNT_W)) u_bgm_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .busy           (busy),
  .out_valid      (out_valid),
  .out_mean_value (out_mean_value),
  .out_item_count (out_item_count)
);

### dv/tb_byte_geometric_mean_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_byte_geometric_mean_unit
// Self-checking bench for the streaming byte geometric mean unit.
// Bytes are sent in sets through the start/busy command port, in random bursts
// in the random-set test. A fixed-point log/exp predictor works out mean and
// count for each closed set, and every out_valid result is compared in order.
// ----------------------------------------------------------------------------
module tb_byte_geometric_mean_unit;

  localparam longint unsigned SET_LIMIT = 64'd16777216;
  localparam longint unsigned ONE_FIX = 64'd1 << 56;
  localparam int CYCLE_LIMIT = 10000000;
  localparam int DRAIN_CYCLES = 4000;

  typedef struct packed {
    logic [23:0] mean;
    logic [24:0] count;
  } mean_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [7:0]  in_sample = '0;
  logic        in_last = 1'b0;
  logic        out_valid;
  logic [23:0] out_mean_value;
  logic [24:0] out_item_count;

  longint unsigned ln_table [256];
  longint unsigned ln2_fix;
  longint unsigned set_log_sum;
  longint unsigned set_count;
  mean_result_t    expected_means [$];
  int              errors = 0;
  int              items_sent = 0;
  int              cycles = 0;
  int              burst_left = 0;

  byte_geometric_mean_unit dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_sample(in_sample), .in_last(in_last), .out_valid(out_valid),
    .out_mean_value(out_mean_value), .out_item_count(out_item_count)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // 2*atanh(a/b) in Q.56
  function automatic longint unsigned atanh_pair(longint unsigned a, longint unsigned b);
    longint unsigned t, sum, i;
    t = (a << 56) / b;
    sum = 0;
    i = 1;
    while (t != 0 && i < 200) begin
      sum += t / i;
      t = t * a / b;
      t = t * a / b;
      i += 2;
    end
    return sum * 2;
  endfunction

  function automatic void init_ln_table();
    longint unsigned e, p, v;
    ln2_fix = atanh_pair(1, 3);
    ln_table[0] = 0;
    for (int k = 1; k < 256; k++) begin
      e = 0;
      p = 1;
      while (p * 2 <= k) begin
        p *= 2;
        e++;
      end
      v = e * ln2_fix + atanh_pair(k - p, k + p);
      ln_table[k] = (v + (64'd1 << 39)) >> 40;
    end
  endfunction

  function automatic logic [23:0] exp_to_mean(longint unsigned x);
    longint unsigned k, r, sum, t, s, res;
    logic [127:0] prod;
    k = x / ln2_fix;
    if (k > 7) k = 7;
    r = x - k * ln2_fix;
    if (r > ONE_FIX) r = ONE_FIX;
    sum = ONE_FIX;
    t = ONE_FIX;
    for (longint unsigned i = 1; i < 40 && t != 0; i++) begin
      prod = 128'(t) * 128'(r);
      t = prod[119:56] / i;
      sum += t;
    end
    s = 40 - k;
    res = (sum + (64'd1 << (s - 1))) >> s;
    if (res > (64'd255 << 16)) res = 64'd255 << 16;
    if (res < (64'd1 << 16)) res = 64'd1 << 16;
    return res[23:0];
  endfunction

  function automatic void predict_byte(logic [7:0] smp, logic fin);
    longint unsigned cnt;
    logic [127:0] mean_log;
    mean_result_t r;
    if (set_count < SET_LIMIT) begin
      set_count++;
      set_log_sum += ln_table[smp];
    end
    if (fin) begin
      cnt = (set_count == 0) ? 1 : set_count;
      mean_log = (128'(set_log_sum) << 40) / 128'(cnt);
      r.mean = exp_to_mean(mean_log[63:0]);
      r.count = set_count[24:0];
      expected_means.push_back(r);
      set_log_sum = 0;
      set_count = 0;
    end
  endfunction

  always @(negedge clk) begin
    mean_result_t want;
    if (rst_n && out_valid) begin
      if (expected_means.size() == 0) begin
        $display("%0t: unexpected result mean=%h count=%0d", $time,
                 out_mean_value, out_item_count);
        errors++;
      end else begin
        want = expected_means.pop_front();
        if (out_mean_value !== want.mean) begin
          $display("%0t: mean_value expected %h actual %h", $time, want.mean,
                   out_mean_value);
          errors++;
        end
        if (out_item_count !== want.count) begin
          $display("%0t: item_count expected %0d actual %0d", $time, want.count,
                   out_item_count);
          errors++;
        end
      end
    end
  end

  // drives one item, holds until accepted; start stays high for the next call
  task automatic send_byte(logic [7:0] smp, logic fin, bit bursty);
    int gap;
    if (bursty) begin
      if (burst_left == 0) begin
        gap = $urandom_range(1, 20);
        start <= 1'b0;
        repeat (gap) @(posedge clk);
        burst_left = $urandom_range(1, 30);
      end
      burst_left--;
    end
    start <= 1'b1;
    in_sample <= smp;
    in_last <= fin;
    forever begin
      @(negedge clk);
      if (!busy) break;
    end
    @(posedge clk);
    predict_byte(smp, fin);
    items_sent++;
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (expected_means.size() != 0) @(posedge clk);
  endtask

  task automatic test_single_bytes();
    send_byte(8'd0, 1'b1, 1'b0);
    send_byte(8'd255, 1'b1, 1'b0);
    send_byte(8'd1, 1'b1, 1'b0);
    send_byte(8'd2, 1'b1, 1'b0);
    send_byte(8'd128, 1'b1, 1'b0);
    send_byte(8'd85, 1'b1, 1'b0);
    send_byte(8'd170, 1'b1, 1'b0);
  endtask

  task automatic test_zero_sets();
    repeat (3) send_byte(8'd0, 1'b0, 1'b0);
    send_byte(8'd0, 1'b1, 1'b0);
    send_byte(8'd0, 1'b0, 1'b0);
    send_byte(8'd255, 1'b1, 1'b0);
  endtask

  task automatic test_extreme_mix();
    for (int i = 0; i < 8; i++) send_byte(8'd255, i == 7, 1'b0);
    send_byte(8'd1, 1'b0, 1'b0);
    send_byte(8'd255, 1'b0, 1'b0);
    send_byte(8'd127, 1'b1, 1'b0);
  endtask

  task automatic test_drain_pause();
    send_byte(8'd200, 1'b0, 1'b0);
    send_byte(8'd3, 1'b1, 1'b0);
    wait_drained();
    send_byte(8'd64, 1'b1, 1'b0);
  endtask

  task automatic test_random_sets();
    int len, mode;
    logic [7:0] smp;
    while (items_sent < 600) begin
      len = ($urandom_range(0, 19) == 0) ? $urandom_range(40, 200)
                                         : $urandom_range(1, 16);
      mode = $urandom_range(0, 3);
      for (int i = 0; i < len; i++) begin
        case (mode)
          0: smp = 8'($urandom_range(0, 3));
          1: smp = 8'($urandom_range(248, 255));
          default: smp = 8'($urandom_range(0, 255));
        endcase
        send_byte(smp, (i == len - 1) || ($urandom_range(0, 49) == 0), 1'b1);
      end
    end
  endtask

  initial begin
    init_ln_table();
    set_log_sum = 0;
    set_count = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_single_bytes();
    test_zero_sets();
    test_extreme_mix();
    test_drain_pause();
    test_random_sets();
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

### files.f
+incdir+rtl/core
rtl/core/bgm_pkg.sv
rtl/core/bgm_front.sv
rtl/core/bgm_queue.sv
rtl/core/bgm_div.sv
rtl/core/bgm_back.sv
rtl/core/byte_geometric_mean_unit.sv
rtl/core/bgm_checker.sv
dv/tb_byte_geometric_mean_unit.sv
